// ===== hdl/pulse_beat_rate_detector_unit_defines.svh =====
// Assertion macros shared by the pulse beat rate detector RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef PULSE_BEAT_RATE_DETECTOR_UNIT_DEFINES_SVH
`define PULSE_BEAT_RATE_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbrd: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbrd: assertion failed");

`endif

// ===== hdl/pbrd_pkg.sv =====
// Shared types, constants and the microcode table of the pulse beat rate detector.
// Depends on nothing; used by every other file of the block except the defines header.
package pbrd_pkg;

  // Default parameter values.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int TIME_BITS_DEF   = 32;

  // Fixed widths of the configuration fields.
  localparam int Q_W         = 16;  // Q0.16 ratio, decay and blend
  localparam int MIN_SWING_W = 12;
  localparam int MS_W        = 16;
  localparam int BPM_W       = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;

  // Rate numerator: milliseconds per minute.
  localparam int RATE_NUM   = 60000;
  localparam int RATE_NUM_W = 16;

  // Reset value of the smoothed threshold, integer part.
  localparam int THR_RESET = 2020;

  localparam int UPC_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_RATIO = 3'd0,
    CFG_ENVELOPE_DECAY  = 3'd1,
    CFG_THRESHOLD_BLEND = 3'd2,
    CFG_MIN_SWING       = 3'd3,
    CFG_REFRACTORY_MS   = 3'd4,
    CFG_RATE_LOW_BPM    = 3'd5,
    CFG_RATE_HIGH_BPM   = 3'd6,
    CFG_ALARM_BPM       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [Q_W-1:0]         threshold_ratio;
    logic [Q_W-1:0]         envelope_decay;
    logic [Q_W-1:0]         threshold_blend;
    logic [MIN_SWING_W-1:0] min_swing;
    logic [MS_W-1:0]        refractory_ms;
    logic [BPM_W-1:0]       rate_low_bpm;
    logic [BPM_W-1:0]       rate_high_bpm;
    logic [BPM_W-1:0]       alarm_bpm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    threshold_ratio: 16'd45875,
    envelope_decay:  16'd655,
    threshold_blend: 16'd3277,
    min_swing:       12'd5,
    refractory_ms:   16'd300,
    rate_low_bpm:    8'd50,
    rate_high_bpm:   8'd250,
    alarm_bpm:       8'd130
  };

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SWING,
    OP_MUL_RATIO,
    OP_TARGET,
    OP_MUL_THR,
    OP_ACC_MUL,
    OP_BLEND,
    OP_CLAMP,
    OP_BEAT,
    OP_DIV,
    OP_RATE,
    OP_MUL_DMAX,
    OP_DEC_MAX,
    OP_DEC_MIN,
    OP_OUT
  } op_e;

  // Jump conditions; the jump is taken when the condition holds.
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_NO_RATE,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] jump;
    logic [UPC_W-1:0] next;
  } uword_t;

  // Status the datapath reports to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic rate_go;
    logic div_busy;
  } seq_stat_t;

  // Step addresses that are jump targets.
  localparam logic [UPC_W-1:0] ST_LOAD  = 4'd0;
  localparam logic [UPC_W-1:0] ST_DIV   = 4'd9;
  localparam logic [UPC_W-1:0] ST_DECAY = 4'd11;
  localparam logic [UPC_W-1:0] ST_OUT   = 4'd14;

  function automatic uword_t uw(input op_e op, input cond_e cond,
                                input logic [UPC_W-1:0] jump,
                                input logic [UPC_W-1:0] next);
    uword_t w;
    w.op   = op;
    w.cond = cond;
    w.jump = jump;
    w.next = next;
    return w;
  endfunction

  // Microcode program: one word per sample-processing step.
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = uw(OP_LOAD,      C_NO_INPUT, ST_LOAD,  4'd1);
      4'd1:    w = uw(OP_SWING,     C_NEVER,    ST_LOAD,  4'd2);
      4'd2:    w = uw(OP_MUL_RATIO, C_NEVER,    ST_LOAD,  4'd3);
      4'd3:    w = uw(OP_TARGET,    C_NEVER,    ST_LOAD,  4'd4);
      4'd4:    w = uw(OP_MUL_THR,   C_NEVER,    ST_LOAD,  4'd5);
      4'd5:    w = uw(OP_ACC_MUL,   C_NEVER,    ST_LOAD,  4'd6);
      4'd6:    w = uw(OP_BLEND,     C_NEVER,    ST_LOAD,  4'd7);
      4'd7:    w = uw(OP_CLAMP,     C_NEVER,    ST_LOAD,  4'd8);
      4'd8:    w = uw(OP_BEAT,      C_NO_RATE,  ST_DECAY, ST_DIV);
      4'd9:    w = uw(OP_DIV,       C_DIV_BUSY, ST_DIV,   4'd10);
      4'd10:   w = uw(OP_RATE,      C_NEVER,    ST_LOAD,  ST_DECAY);
      4'd11:   w = uw(OP_MUL_DMAX,  C_NEVER,    ST_LOAD,  4'd12);
      4'd12:   w = uw(OP_DEC_MAX,   C_NEVER,    ST_LOAD,  4'd13);
      4'd13:   w = uw(OP_DEC_MIN,   C_NEVER,    ST_LOAD,  ST_OUT);
      4'd14:   w = uw(OP_OUT,       C_OUT_BUSY, ST_OUT,   ST_LOAD);
      default: w = uw(OP_NOP,       C_NEVER,    ST_LOAD,  ST_LOAD);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/pbrd_stream_if.sv =====
// Valid/ready stream interfaces for the sample input and the result output.
// Depends on pbrd_pkg for default widths.
interface pbrd_in_if #(
  parameter int SAMPLE_BITS = pbrd_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = pbrd_pkg::TIME_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_BITS-1:0]   time_ms;

  modport source (output valid, output sample, output time_ms, input ready);
  modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

interface pbrd_out_if #(
  parameter int SAMPLE_BITS = pbrd_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [SAMPLE_BITS-1:0]       sample_out;
  logic                         beat;
  logic                         rate_valid;
  logic [pbrd_pkg::BPM_W-1:0]   rate_bpm;
  logic                         alarm;

  modport source (output valid, output sample_out, output beat, output rate_valid,
                  output rate_bpm, output alarm, input ready);
  modport sink   (input valid, input sample_out, input beat, input rate_valid,
                  input rate_bpm, input alarm, output ready);
endinterface

// ===== hdl/pbrd_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
// Depends on pbrd_pkg for the control word, the program and the status struct.
module pbrd_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbrd_pkg::seq_stat_t stat_i,
  output pbrd_pkg::op_e       op_o
);

  logic [pbrd_pkg::UPC_W-1:0] pc_q, pc_d;
  pbrd_pkg::uword_t           word;
  logic                       take;

  always_comb begin
    word = pbrd_pkg::ucode_rom(pc_q);
    case (word.cond)
      pbrd_pkg::C_NEVER:    take = 1'b0;
      pbrd_pkg::C_NO_INPUT: take = !stat_i.in_valid;
      pbrd_pkg::C_NO_RATE:  take = !stat_i.rate_go;
      pbrd_pkg::C_DIV_BUSY: take = stat_i.div_busy;
      pbrd_pkg::C_OUT_BUSY: take = !stat_i.out_free;
      default:              take = 1'b0;
    endcase
    pc_d = take ? word.jump : word.next;
    op_o = word.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= pbrd_pkg::ST_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hdl/pbrd_dp.sv =====
// Datapath of the pulse beat rate detector: envelopes, threshold, shared multiplier,
// serial rate divider and output register. Depends on pbrd_pkg and the defines header.
`include "pulse_beat_rate_detector_unit_defines.svh"

module pbrd_dp #(
  parameter int SAMPLE_BITS = pbrd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = pbrd_pkg::FRAC_BITS_DEF,
  parameter int TIME_BITS   = pbrd_pkg::TIME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pbrd_pkg::op_e              op_i,
  input  pbrd_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  input  logic [SAMPLE_BITS-1:0]     sample_i,
  input  logic [TIME_BITS-1:0]       time_ms_i,
  input  logic                       out_ready_i,
  output pbrd_pkg::seq_stat_t        stat_o,
  output logic                       out_valid_o,
  output logic [SAMPLE_BITS-1:0]     sample_out_o,
  output logic                       beat_o,
  output logic                       rate_valid_o,
  output logic [pbrd_pkg::BPM_W-1:0] rate_bpm_o,
  output logic                       alarm_o
);

  localparam int W     = SAMPLE_BITS + FRAC_BITS;
  localparam int QW    = pbrd_pkg::Q_W;
  localparam int MB    = QW + 1;
  localparam int PW    = W + MB;
  localparam int SWW   = pbrd_pkg::MIN_SWING_W + FRAC_BITS;
  localparam int CMPW  = (W > SWW) ? W : SWW;
  localparam int NW    = pbrd_pkg::RATE_NUM_W;
  localparam int DCW   = $clog2(NW);
  localparam int BW    = pbrd_pkg::BPM_W;
  localparam logic [MB-1:0]  Q_ONE    = MB'(1) << QW;
  localparam logic [DCW-1:0] DIV_LAST = DCW'(NW - 1);
  localparam logic [W-1:0]   MIN_RST  = W'({SAMPLE_BITS{1'b1}}) << FRAC_BITS;
  localparam logic [W-1:0]   THR_RST  = W'(pbrd_pkg::THR_RESET) << FRAC_BITS;

  // Persistent detector state.
  logic [W-1:0]           max_q, max_d, min_q, min_d, thr_q, thr_d;
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [TIME_BITS-1:0]   last_beat_q, last_beat_d;
  logic                   beat_seen_q, beat_seen_d, alarm_q, alarm_d;

  // Per-sample working registers.
  logic [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic [TIME_BITS-1:0]   now_q, now_d, dt_q, dt_d, rem_q, rem_d;
  logic [W-1:0]           swing_q, swing_d, tgt_q, tgt_d;
  logic [PW-1:0]          prod_q, prod_d, acc_q, acc_d;
  logic [NW-1:0]          quo_q, quo_d;
  logic [DCW-1:0]         div_cnt_q, div_cnt_d;
  logic                   beat_q, beat_d, rv_q, rv_d;
  logic [BW-1:0]          bpm_q, bpm_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_smp_q, out_smp_d;
  logic                   out_beat_q, out_beat_d, out_rv_q, out_rv_d, out_alarm_q, out_alarm_d;
  logic [BW-1:0]          out_bpm_q, out_bpm_d;

  logic [W-1:0]      s_fix, prev_fix, s_in_fix, thr_lo;
  logic [W-1:0]      mul_a;
  logic [MB-1:0]     mul_b;
  logic [PW:0]       blend_sum;
  logic [TIME_BITS:0] trial, dt_ext;
  logic              div_ge, swing_ok, beat_now, out_free, in_fire;
  logic              div_end, thr_in_env;

  assign s_fix    = W'(smp_q) << FRAC_BITS;
  assign prev_fix = W'(prev_q) << FRAC_BITS;
  assign s_in_fix = W'(sample_i) << FRAC_BITS;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_fire  = (op_i == pbrd_pkg::OP_LOAD) && in_valid_i;

  assign swing_ok = CMPW'(swing_q) > (CMPW'(cfg_i.min_swing) << FRAC_BITS);
  assign beat_now = (s_fix >= thr_q) && (prev_fix < thr_q) && swing_ok
                    && (dt_q > TIME_BITS'(cfg_i.refractory_ms));

  assign trial  = {rem_q, quo_q[NW-1]};
  assign dt_ext = {1'b0, dt_q};
  assign div_ge = trial >= dt_ext;

  assign blend_sum = (PW+1)'(acc_q) + (PW+1)'(prod_q);
  assign thr_lo    = (thr_q < min_q) ? min_q : thr_q;

  assign stat_o.in_valid = in_valid_i;
  assign stat_o.out_free = out_free;
  assign stat_o.rate_go  = beat_now && beat_seen_q;
  assign stat_o.div_busy = div_cnt_q != DIV_LAST;

  // Last divider step, and the threshold lying between the envelopes.
  assign div_end    = (op_i == pbrd_pkg::OP_DIV) && (div_cnt_q == DIV_LAST);
  assign thr_in_env = (thr_q >= min_q) && (thr_q <= max_q);

  // Shared multiplier operand selection; the product is registered every cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      pbrd_pkg::OP_MUL_RATIO: begin
        mul_a = swing_q;
        mul_b = MB'(cfg_i.threshold_ratio);
      end
      pbrd_pkg::OP_MUL_THR: begin
        mul_a = thr_q;
        mul_b = Q_ONE - MB'(cfg_i.threshold_blend);
      end
      pbrd_pkg::OP_ACC_MUL: begin
        mul_a = tgt_q;
        mul_b = MB'(cfg_i.threshold_blend);
      end
      pbrd_pkg::OP_MUL_DMAX: begin
        mul_a = max_q - s_fix;
        mul_b = MB'(cfg_i.envelope_decay);
      end
      pbrd_pkg::OP_DEC_MAX: begin
        mul_a = s_fix - min_q;
        mul_b = MB'(cfg_i.envelope_decay);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    max_d       = max_q;
    min_d       = min_q;
    thr_d       = thr_q;
    prev_d      = prev_q;
    last_beat_d = last_beat_q;
    beat_seen_d = beat_seen_q;
    alarm_d     = alarm_q;
    smp_d       = smp_q;
    now_d       = now_q;
    dt_d        = dt_q;
    rem_d       = rem_q;
    swing_d     = swing_q;
    tgt_d       = tgt_q;
    acc_d       = acc_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    beat_d      = beat_q;
    rv_d        = rv_q;
    bpm_d       = bpm_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_smp_d   = out_smp_q;
    out_beat_d  = out_beat_q;
    out_rv_d    = out_rv_q;
    out_bpm_d   = out_bpm_q;
    out_alarm_d = out_alarm_q;
    case (op_i)
      pbrd_pkg::OP_LOAD: begin
        if (in_fire) begin
          smp_d = sample_i;
          now_d = time_ms_i;
          // Envelopes first jump to cover the new sample.
          if (s_in_fix > max_q) begin
            max_d = s_in_fix;
          end
          if (s_in_fix < min_q) begin
            min_d = s_in_fix;
          end
        end
      end
      pbrd_pkg::OP_SWING: begin
        swing_d = max_q - min_q;
        dt_d    = now_q - last_beat_q;
      end
      pbrd_pkg::OP_TARGET: begin
        tgt_d = min_q + W'(prod_q >> QW);
      end
      pbrd_pkg::OP_ACC_MUL: begin
        acc_d = prod_q;
      end
      pbrd_pkg::OP_BLEND: begin
        thr_d = W'(blend_sum >> QW);
      end
      pbrd_pkg::OP_CLAMP: begin
        thr_d = (thr_lo > max_q) ? max_q : thr_lo;
      end
      pbrd_pkg::OP_BEAT: begin
        beat_d    = beat_now;
        rv_d      = 1'b0;
        bpm_d     = '0;
        rem_d     = '0;
        quo_d     = NW'(pbrd_pkg::RATE_NUM);
        div_cnt_d = '0;
        if (beat_now) begin
          last_beat_d = now_q;
          beat_seen_d = 1'b1;
        end
      end
      pbrd_pkg::OP_DIV: begin
        // One restoring step: one quotient bit per cycle, MSB first.
        rem_d     = div_ge ? TIME_BITS'(trial - dt_ext) : trial[TIME_BITS-1:0];
        quo_d     = {quo_q[NW-2:0], div_ge};
        div_cnt_d = div_cnt_q + DCW'(1);
      end
      pbrd_pkg::OP_RATE: begin
        if (quo_q > NW'(cfg_i.rate_low_bpm) && quo_q < NW'(cfg_i.rate_high_bpm)) begin
          rv_d    = 1'b1;
          bpm_d   = quo_q[BW-1:0];
          alarm_d = quo_q >= NW'(cfg_i.alarm_bpm);
        end
      end
      pbrd_pkg::OP_DEC_MAX: begin
        max_d = max_q - W'(prod_q >> QW);
      end
      pbrd_pkg::OP_DEC_MIN: begin
        min_d  = min_q + W'(prod_q >> QW);
        prev_d = smp_q;
      end
      pbrd_pkg::OP_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_smp_d   = smp_q;
          out_beat_d  = beat_q;
          out_rv_d    = rv_q;
          out_bpm_d   = bpm_q;
          out_alarm_d = alarm_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '0;
      min_q       <= MIN_RST;
      thr_q       <= THR_RST;
      prev_q      <= '1;
      last_beat_q <= '0;
      beat_seen_q <= 1'b0;
      alarm_q     <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      max_q       <= max_d;
      min_q       <= min_d;
      thr_q       <= thr_d;
      prev_q      <= prev_d;
      last_beat_q <= last_beat_d;
      beat_seen_q <= beat_seen_d;
      alarm_q     <= alarm_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q       <= smp_d;
    now_q       <= now_d;
    dt_q        <= dt_d;
    rem_q       <= rem_d;
    swing_q     <= swing_d;
    tgt_q       <= tgt_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    quo_q       <= quo_d;
    beat_q      <= beat_d;
    rv_q        <= rv_d;
    bpm_q       <= bpm_d;
    out_smp_q   <= out_smp_d;
    out_beat_q  <= out_beat_d;
    out_rv_q    <= out_rv_d;
    out_bpm_q   <= out_bpm_d;
    out_alarm_q <= out_alarm_d;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_smp_q;
  assign beat_o       = out_beat_q;
  assign rate_valid_o = out_rv_q;
  assign rate_bpm_o   = out_bpm_q;
  assign alarm_o      = out_alarm_q;

  `PBRD_ASSERT_IMP(a_rate_after_beat, clk_i, rst_ni, op_i == pbrd_pkg::OP_RATE, beat_q)
  `PBRD_ASSERT_NXT(a_div_done, clk_i, rst_ni, div_end, op_i == pbrd_pkg::OP_RATE)
  `PBRD_ASSERT_IMP(a_thr_clamped, clk_i, rst_ni, op_i == pbrd_pkg::OP_BEAT, thr_in_env)
  `PBRD_ASSERT_IMP(a_rate_has_beat, clk_i, rst_ni, out_valid_q && out_rv_q, out_beat_q)
  `PBRD_ASSERT_NXT(a_out_loaded, clk_i, rst_ni, op_i == pbrd_pkg::OP_OUT && out_free, out_valid_q)

endmodule

// ===== hdl/pulse_beat_rate_detector_unit.sv =====
// Top level of the pulse beat rate detector: configuration registers, sequencer and datapath.
// Depends on pbrd_pkg, pbrd_stream_if, pbrd_seq and pbrd_dp.
//
// Usage: each input beat on in_i carries one sensor sample and its millisecond timestamp;
// each accepted sample yields exactly one output beat on out_o carrying the sample, a beat
// flag, the heart rate (with its valid flag) and the current alarm level.
// The block works on one sample at a time under a microcoded sequencer. A sample that
// produces a rate (second and later beats) runs the 60000/interval division in a restoring
// divider that retires one quotient bit per cycle; other samples skip the divider steps.
// The output sits in its own register, so the next sample is accepted while a result is
// still waiting; if the receiver stalls, the sequencer holds at its output step until the
// register frees up, and the input stays not ready meanwhile.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i, one register per cycle;
// the user must write it only while the block is idle, which the block itself does not enforce.
// Reset restores all configuration registers to their defaults, empties the output register
// and returns the envelopes, threshold and beat history to their initial values; the block
// is ready for a sample in the first cycle after reset.
module pulse_beat_rate_detector_unit #(
  parameter int SAMPLE_BITS = pbrd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = pbrd_pkg::FRAC_BITS_DEF,
  parameter int TIME_BITS   = pbrd_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pbrd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pbrd_in_if.sink                         in_i,
  pbrd_out_if.source                      out_o
);

  pbrd_pkg::cfg_t      cfg_q, cfg_d;
  pbrd_pkg::op_e       op;
  pbrd_pkg::seq_stat_t stat;

  // Register file: the index selects one field, which takes the low bits of the data.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pbrd_pkg::cfg_idx_e'(cfg_idx_i))
        pbrd_pkg::CFG_THRESHOLD_RATIO:
          cfg_d.threshold_ratio = cfg_data_i[pbrd_pkg::Q_W-1:0];
        pbrd_pkg::CFG_ENVELOPE_DECAY:
          cfg_d.envelope_decay = cfg_data_i[pbrd_pkg::Q_W-1:0];
        pbrd_pkg::CFG_THRESHOLD_BLEND:
          cfg_d.threshold_blend = cfg_data_i[pbrd_pkg::Q_W-1:0];
        pbrd_pkg::CFG_MIN_SWING:
          cfg_d.min_swing = cfg_data_i[pbrd_pkg::MIN_SWING_W-1:0];
        pbrd_pkg::CFG_REFRACTORY_MS:
          cfg_d.refractory_ms = cfg_data_i[pbrd_pkg::MS_W-1:0];
        pbrd_pkg::CFG_RATE_LOW_BPM:
          cfg_d.rate_low_bpm = cfg_data_i[pbrd_pkg::BPM_W-1:0];
        pbrd_pkg::CFG_RATE_HIGH_BPM:
          cfg_d.rate_high_bpm = cfg_data_i[pbrd_pkg::BPM_W-1:0];
        pbrd_pkg::CFG_ALARM_BPM:
          cfg_d.alarm_bpm = cfg_data_i[pbrd_pkg::BPM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pbrd_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The input is ready only at the load step of the program.
  assign in_i.ready = (op == pbrd_pkg::OP_LOAD);

  pbrd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  pbrd_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_i.valid),
    .sample_i     (in_i.sample),
    .time_ms_i    (in_i.time_ms),
    .out_ready_i  (out_o.ready),
    .stat_o       (stat),
    .out_valid_o  (out_o.valid),
    .sample_out_o (out_o.sample_out),
    .beat_o       (out_o.beat),
    .rate_valid_o (out_o.rate_valid),
    .rate_bpm_o   (out_o.rate_bpm),
    .alarm_o      (out_o.alarm)
  );

endmodule
